// File: rtl/core/plc_pkg.sv
// Shared constants for the positional list engine: capacity, field widths, action, status and cell mode codes.
`default_nettype none

package plc_pkg;

  // Default list capacity
  localparam int CAPACITY_DEF = 16;

  // Field widths
  localparam int ACTION_W = 4;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int SIZE_W   = 5;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_ADD_HEAD = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD_TAIL = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_INSERT   = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_SEARCH   = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_DEL_HEAD = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_DEL_TAIL = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_DEL_AT   = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_SET_HEAD = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_SET_TAIL = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_SET_AT   = 4'd9;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // Cell update modes, broadcast along the chain
  localparam logic [1:0] MODE_HOLD = 2'd0;
  localparam logic [1:0] MODE_INS  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;
  localparam logic [1:0] MODE_SET  = 2'd3;

endpackage

`default_nettype wire

// File: rtl/core/plc_cell.sv
// One list slot: holds an entry, shifts with its neighbors and compares against the search key.
`default_nettype none

module plc_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  wire logic                               clk,
  input  wire logic [1:0]                         cell_mode,
  input  wire logic [IW-1:0]                      tgt,
  input  wire logic signed [plc_pkg::VALUE_W-1:0] value,
  input  wire logic signed [plc_pkg::VALUE_W-1:0] left_data,
  input  wire logic signed [plc_pkg::VALUE_W-1:0] right_data,
  output logic signed [plc_pkg::VALUE_W-1:0]      data,
  output logic                                    match
);

  logic signed [plc_pkg::VALUE_W-1:0] data_r;
  logic                               at_tgt;
  logic                               past_tgt;

  // Where this slot sits relative to the target slot
  assign at_tgt   = (IW'(IDX) == tgt);
  assign past_tgt = (IW'(IDX) > tgt);

  // Insert opens a gap at the target, delete closes it, set overwrites in place
  always_ff @(posedge clk) begin
    case (cell_mode)
      plc_pkg::MODE_INS: begin
        if (at_tgt) begin
          data_r <= value;
        end else if (past_tgt) begin
          data_r <= left_data;
        end
      end
      plc_pkg::MODE_DEL: begin
        if (at_tgt || past_tgt) begin
          data_r <= right_data;
        end
      end
      plc_pkg::MODE_SET: begin
        if (at_tgt) begin
          data_r <= value;
        end
      end
      default: begin
        data_r <= data_r;
      end
    endcase
  end

  assign data  = data_r;
  assign match = (data_r == value);

endmodule

`default_nettype wire

// File: rtl/core/plc_first.sv
// First-match encoder: index of the lowest set bit of the registered match vector.
`default_nettype none

module plc_first #(
  parameter int N  = 16,
  parameter int IW = 4
) (
  input  wire logic [N-1:0] match,
  output logic              found,
  output logic [IW-1:0]     idx
);

  logic [N-1:0] lowest;

  // Isolate the lowest set bit
  assign lowest = match & (~match + N'(1));
  assign found  = |match;

  // Encode the one-hot vector
  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (lowest[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/positional_list_engine.sv
// Top level of the positional list engine: decode, cell chain, search stage and result register.
//
//   channel   dir   handshake             payload
//   in_       in    in_valid/in_ready     in_action, in_position, in_value
//   out_      out   out_valid/out_ready   out_status, out_found_position, out_list_size
//
// One beat is taken per cycle while out_ is not stalled; its result passes the search
// stage and then the result register. The chain of cells updates at the accept edge;
// match bits are registered there and encoded in the next cycle by the first-match unit.
// Reset clears the entry count and the valid flags; the entries themselves are not cleared.
// A stalled result holds the search stage, which in turn holds off the input.
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [plc_pkg::ACTION_W-1:0]        in_action,
  input  wire logic [plc_pkg::POS_W-1:0]           in_position,
  input  wire logic signed [plc_pkg::VALUE_W-1:0]  in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [plc_pkg::STATUS_W-1:0]             out_status,
  output logic [plc_pkg::POS_W-1:0]                out_found_position,
  output logic [plc_pkg::SIZE_W-1:0]               out_list_size
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW  = ((CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W) + 1;
  localparam int FW  = ((IW + 1) > plc_pkg::POS_W) ? (IW + 1) : plc_pkg::POS_W;
  localparam int SW  = (CW > plc_pkg::SIZE_W) ? CW : plc_pkg::SIZE_W;

  logic [CW-1:0]                 count_r, count_nxt;
  logic                          stg_busy_r;
  logic [plc_pkg::STATUS_W-1:0]  stg_status_r;
  logic                          stg_search_r;
  logic [CW-1:0]                 stg_size_r;
  logic [CAPACITY-1:0]           match_r;
  logic                          out_valid_r;
  logic [plc_pkg::STATUS_W-1:0]  out_status_r;
  logic [plc_pkg::POS_W-1:0]     out_found_r;
  logic [plc_pkg::SIZE_W-1:0]    out_size_r;

  logic                          accept;
  logic                          move;
  logic [1:0]                    dec_mode;
  logic [1:0]                    cell_mode;
  logic [IW-1:0]                 dec_tgt;
  logic [plc_pkg::STATUS_W-1:0]  dec_status;
  logic                          dec_search;
  logic                          full;
  logic                          empty;
  logic [PW-1:0]                 pos_x;
  logic [PW-1:0]                 cnt_x;
  logic                          ins_bad;
  logic                          at_bad;
  logic [IW-1:0]                 pos_idx;

  logic signed [plc_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]           cell_match;
  logic [CAPACITY-1:0]           live;
  logic                          first_found;
  logic [IW-1:0]                 first_idx;
  logic [FW-1:0]                 found_w;
  logic [SW-1:0]                 size_w;
  logic [plc_pkg::STATUS_W-1:0]  res_status;
  logic [plc_pkg::POS_W-1:0]     res_found;

  // Handshake: the search stage drains into the result register when it is free
  assign move     = stg_busy_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_busy_r || move;
  assign accept   = in_valid && in_ready;

  // Range checks against the current count
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign pos_x   = PW'(in_position);
  assign cnt_x   = PW'(count_r);
  assign ins_bad = (pos_x == '0) || (pos_x > cnt_x + PW'(1));
  assign at_bad  = (pos_x == '0) || (pos_x > cnt_x);
  assign pos_idx = IW'(pos_x - PW'(1));

  // Operation decode
  always_comb begin
    dec_mode   = plc_pkg::MODE_HOLD;
    dec_tgt    = '0;
    dec_status = plc_pkg::ST_OK;
    dec_search = 1'b0;
    count_nxt  = count_r;
    case (in_action)
      plc_pkg::ACT_ADD_HEAD, plc_pkg::ACT_ADD_TAIL: begin
        if (full) begin
          dec_status = plc_pkg::ST_FULL;
        end else begin
          dec_mode  = plc_pkg::MODE_INS;
          dec_tgt   = (in_action == plc_pkg::ACT_ADD_HEAD) ? '0 : IW'(count_r);
          count_nxt = count_r + CW'(1);
        end
      end
      plc_pkg::ACT_INSERT: begin
        if (ins_bad) begin
          dec_status = plc_pkg::ST_BADPOS;
        end else if (full) begin
          dec_status = plc_pkg::ST_FULL;
        end else begin
          dec_mode  = plc_pkg::MODE_INS;
          dec_tgt   = pos_idx;
          count_nxt = count_r + CW'(1);
        end
      end
      plc_pkg::ACT_SEARCH: begin
        dec_search = 1'b1;
      end
      plc_pkg::ACT_DEL_HEAD, plc_pkg::ACT_DEL_TAIL: begin
        if (empty) begin
          dec_status = plc_pkg::ST_EMPTY;
        end else begin
          dec_mode  = plc_pkg::MODE_DEL;
          dec_tgt   = (in_action == plc_pkg::ACT_DEL_HEAD) ? '0 : IW'(count_r - CW'(1));
          count_nxt = count_r - CW'(1);
        end
      end
      plc_pkg::ACT_DEL_AT: begin
        if (at_bad) begin
          dec_status = plc_pkg::ST_BADPOS;
        end else begin
          dec_mode  = plc_pkg::MODE_DEL;
          dec_tgt   = pos_idx;
          count_nxt = count_r - CW'(1);
        end
      end
      plc_pkg::ACT_SET_HEAD, plc_pkg::ACT_SET_TAIL: begin
        if (empty) begin
          dec_status = plc_pkg::ST_EMPTY;
        end else begin
          dec_mode = plc_pkg::MODE_SET;
          dec_tgt  = (in_action == plc_pkg::ACT_SET_HEAD) ? '0 : IW'(count_r - CW'(1));
        end
      end
      plc_pkg::ACT_SET_AT: begin
        if (at_bad) begin
          dec_status = plc_pkg::ST_BADPOS;
        end else begin
          dec_mode = plc_pkg::MODE_SET;
          dec_tgt  = pos_idx;
        end
      end
      default: begin
        dec_status = plc_pkg::ST_OK;
      end
    endcase
  end

  assign cell_mode = accept ? dec_mode : plc_pkg::MODE_HOLD;

  // Chain of cells; each takes from its left neighbor on insert, its right on delete
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [plc_pkg::VALUE_W-1:0] left_d;
    logic signed [plc_pkg::VALUE_W-1:0] right_d;

    if (i == 0) begin : g_head
      assign left_d = in_value;
    end else begin : g_body_l
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_body_r
      assign right_d = cell_data[i+1];
    end

    plc_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk        (clk),
      .cell_mode  (cell_mode),
      .tgt        (dec_tgt),
      .value      (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );

    // Only slots below the count take part in a search
    assign live[i] = (CW'(i) < count_r);
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Search stage: status, size and match bits of the accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_busy_r <= 1'b0;
    end else if (accept) begin
      stg_busy_r <= 1'b1;
    end else if (move) begin
      stg_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_status_r <= dec_status;
      stg_search_r <= dec_search;
      stg_size_r   <= count_nxt;
      match_r      <= cell_match & live;
    end
  end

  // First match among the registered bits
  plc_first #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_first (
    .match (match_r),
    .found (first_found),
    .idx   (first_idx)
  );

  assign found_w = FW'(first_idx) + FW'(1);
  assign size_w  = SW'(stg_size_r);

  // Result formation
  always_comb begin
    res_status = stg_status_r;
    res_found  = '0;
    if (stg_search_r) begin
      if (first_found) begin
        res_status = plc_pkg::ST_OK;
        res_found  = found_w[plc_pkg::POS_W-1:0];
      end else begin
        res_status = plc_pkg::ST_NOTFOUND;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_status_r <= res_status;
      out_found_r  <= res_found;
      out_size_r   <= size_w[plc_pkg::SIZE_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_list_size      = out_size_r;

endmodule

`default_nettype wire

// File: rtl/core/plc_checker.sv
// Port-level checks on the positional list engine, bound to the top level.
`default_nettype none

module plc_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [plc_pkg::STATUS_W-1:0]       out_status,
  input wire logic [plc_pkg::POS_W-1:0]          out_found_position,
  input wire logic [plc_pkg::SIZE_W-1:0]         out_list_size
);

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_found_position) && $stable(out_list_size))
    else $error("stalled result beat changed");

  // A found position only comes with an ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_position != '0 |-> out_status == plc_pkg::ST_OK)
    else $error("found position without ok status");

  // Not found means no position is reported
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == plc_pkg::ST_NOTFOUND |-> out_found_position == '0)
    else $error("not found carries a position");

  // The input is never refused while both stages are empty
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid || $past(in_valid && in_ready))
    else $error("input held off with nothing in flight");

endmodule

bind positional_list_engine plc_checker u_plc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_found_position (out_found_position),
  .out_list_size      (out_list_size)
);

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the positional list engine: random list ops, shadow list model.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = plc_pkg::CAPACITY_DEF;
  localparam int NO_ACCEPT_LIMIT = 4000;
  localparam int PHASE_ITEMS = 626;
  localparam int MAX_REPORTS = 10;
  localparam logic [plc_pkg::ACTION_W-1:0] ACT_FIRST_UNUSED = plc_pkg::ACT_SET_AT + 4'd1;
  localparam logic [plc_pkg::ACTION_W-1:0] ACT_TOP = '1;
  localparam logic [plc_pkg::ACTION_W-1:0] KNOWN_ACTIONS [10] = '{
    plc_pkg::ACT_ADD_HEAD, plc_pkg::ACT_ADD_TAIL, plc_pkg::ACT_INSERT, plc_pkg::ACT_SEARCH,
    plc_pkg::ACT_DEL_HEAD, plc_pkg::ACT_DEL_TAIL, plc_pkg::ACT_DEL_AT, plc_pkg::ACT_SET_HEAD,
    plc_pkg::ACT_SET_TAIL, plc_pkg::ACT_SET_AT
  };
  localparam logic signed [plc_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [plc_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [plc_pkg::STATUS_W-1:0] status;
    logic [plc_pkg::POS_W-1:0]    found;
    logic [plc_pkg::SIZE_W-1:0]   size;
  } list_result_t;

  // Shadow copy of the list; computes the result of each operation and checks the block
  class list_scoreboard;
    logic signed [plc_pkg::VALUE_W-1:0] entries [DEPTH];
    int unsigned count;
    int unsigned peak_count;
    list_result_t awaited [$];
    int errors;
    int reports;
    int ops_noted;
    int results_seen;
    int status_hist [5];

    function new();
      count = 0;
      peak_count = 0;
      errors = 0;
      reports = 0;
      ops_noted = 0;
      results_seen = 0;
      foreach (status_hist[i]) status_hist[i] = 0;
    endfunction

    // Make room at idx, later entries move one place toward the tail
    function void open_slot(int unsigned idx, logic signed [plc_pkg::VALUE_W-1:0] v);
      for (int unsigned k = count; k > idx; k--) entries[k] = entries[k-1];
      entries[idx] = v;
      count++;
      if (count > peak_count) peak_count = count;
    endfunction

    // Remove idx, later entries move one place toward the head
    function void close_slot(int unsigned idx);
      for (int unsigned k = idx; k + 1 < count; k++) entries[k] = entries[k+1];
      count--;
    endfunction

    function list_result_t apply_op(logic [plc_pkg::ACTION_W-1:0] act,
                                    logic [plc_pkg::POS_W-1:0] pos,
                                    logic signed [plc_pkg::VALUE_W-1:0] v);
      list_result_t r;
      r.status = plc_pkg::ST_OK;
      r.found = '0;
      case (act)
        plc_pkg::ACT_ADD_HEAD, plc_pkg::ACT_ADD_TAIL: begin
          if (count >= DEPTH) r.status = plc_pkg::ST_FULL;
          else open_slot((act == plc_pkg::ACT_ADD_HEAD) ? 0 : count, v);
        end
        plc_pkg::ACT_INSERT: begin
          // position is checked before fullness
          if (pos < 1 || pos > count + 1) r.status = plc_pkg::ST_BADPOS;
          else if (count >= DEPTH) r.status = plc_pkg::ST_FULL;
          else open_slot(pos - 1, v);
        end
        plc_pkg::ACT_SEARCH: begin
          r.status = plc_pkg::ST_NOTFOUND;
          for (int unsigned k = 0; k < count; k++) begin
            if (r.found == '0 && entries[k] == v) begin
              r.status = plc_pkg::ST_OK;
              r.found = plc_pkg::POS_W'(k + 1);
            end
          end
        end
        plc_pkg::ACT_DEL_HEAD, plc_pkg::ACT_DEL_TAIL: begin
          if (count == 0) r.status = plc_pkg::ST_EMPTY;
          else close_slot((act == plc_pkg::ACT_DEL_HEAD) ? 0 : count - 1);
        end
        plc_pkg::ACT_DEL_AT: begin
          if (pos < 1 || pos > count) r.status = plc_pkg::ST_BADPOS;
          else close_slot(pos - 1);
        end
        plc_pkg::ACT_SET_HEAD, plc_pkg::ACT_SET_TAIL: begin
          if (count == 0) r.status = plc_pkg::ST_EMPTY;
          else entries[(act == plc_pkg::ACT_SET_HEAD) ? 0 : count - 1] = v;
        end
        plc_pkg::ACT_SET_AT: begin
          if (pos < 1 || pos > count) r.status = plc_pkg::ST_BADPOS;
          else entries[pos - 1] = v;
        end
        default: ;  // unused codes leave the list alone
      endcase
      r.size = plc_pkg::SIZE_W'(count);
      return r;
    endfunction

    function void note_input(logic [plc_pkg::ACTION_W-1:0] act, logic [plc_pkg::POS_W-1:0] pos,
                             logic signed [plc_pkg::VALUE_W-1:0] v);
      awaited.push_back(apply_op(act, pos, v));
      ops_noted++;
    endfunction

    function void check_result(logic [plc_pkg::STATUS_W-1:0] st, logic [plc_pkg::POS_W-1:0] fp,
                               logic [plc_pkg::SIZE_W-1:0] sz);
      list_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("[%0t] unexpected result: status %0d found %0d size %0d", $realtime,
                   st, fp, sz);
        end
        return;
      end
      want = awaited.pop_front();
      if (want.status <= plc_pkg::ST_FULL) status_hist[want.status]++;
      if (st !== want.status || fp !== want.found || sz !== want.size) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("[%0t] mismatch: expected status %0d found %0d size %0d, got %0d %0d %0d",
                   $realtime, want.status, want.found, want.size, st, fp, sz);
        end
      end
    endfunction

    // A value currently in the list, for hitting searches and duplicates; a random value if the list is empty
    function logic signed [plc_pkg::VALUE_W-1:0] pick_entry();
      if (count == 0) return $urandom;
      return entries[$urandom_range(count - 1)];
    endfunction
  endclass

  bit clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [plc_pkg::ACTION_W-1:0] in_action = plc_pkg::ACT_ADD_HEAD;
  logic [plc_pkg::POS_W-1:0] in_position = '0;
  logic signed [plc_pkg::VALUE_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [plc_pkg::STATUS_W-1:0] out_status;
  logic [plc_pkg::POS_W-1:0] out_found_position;
  logic [plc_pkg::SIZE_W-1:0] out_list_size;

  int send_idle_pct = 35;
  int recv_idle_pct = 83;
  int no_accept_cycles = 0;
  list_scoreboard sb = new();

  positional_list_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_position(out_found_position),
    .out_list_size     (out_list_size)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Beat monitor: predict on input accept, compare on output accept
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_action, in_position, in_value);
      if (out_valid && out_ready) sb.check_result(out_status, out_found_position, out_list_size);
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) no_accept_cycles <= 0;
    else no_accept_cycles <= no_accept_cycles + 1;
    if (no_accept_cycles >= NO_ACCEPT_LIMIT) begin
      $display("watchdog: %0d cycles without a beat", NO_ACCEPT_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Drive one input beat; entered and left at a falling edge
  task send_op(logic [plc_pkg::ACTION_W-1:0] act, logic [plc_pkg::POS_W-1:0] pos,
               logic signed [plc_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_position <= pos;
    in_value <= v;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  // Random operations; mode biases toward filling, draining or a mix
  task random_ops(int n_items);
    int cuts [3][10];
    int mode;
    int mode_left;
    int r;
    int i;
    logic [plc_pkg::ACTION_W-1:0] act;
    logic [plc_pkg::POS_W-1:0] pos;
    logic signed [plc_pkg::VALUE_W-1:0] v;
    cuts[0] = '{25, 50, 72, 80, 84, 88, 91, 94, 96, 98};  // grow
    cuts[1] = '{4, 8, 13, 23, 43, 63, 85, 89, 93, 98};    // shrink
    cuts[2] = '{10, 20, 32, 46, 55, 64, 75, 83, 90, 98};  // mixed
    mode = $urandom_range(2);
    mode_left = $urandom_range(20, 60);
    for (int n = 0; n < n_items; n++) begin
      if (mode_left == 0) begin
        mode = $urandom_range(2);
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      r = $urandom_range(99);
      i = 0;
      while (i < 10 && r >= cuts[mode][i]) i++;
      act = (i < 10) ? KNOWN_ACTIONS[i]
                     : plc_pkg::ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_TOP));
      // positions mostly near the live range, sometimes anywhere in the field
      if ($urandom_range(99) < 85) pos = plc_pkg::POS_W'($urandom_range(sb.count + 2));
      else pos = plc_pkg::POS_W'($urandom);
      // small pool for duplicates and extremes, live entries for search hits
      r = $urandom_range(99);
      if (r < 40) begin
        case ($urandom_range(5))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = 0;
          3: v = -1;
          4: v = 1;
          default: v = 5;
        endcase
      end else if (r < 70) begin
        v = sb.pick_entry();
      end else begin
        v = $urandom;
      end
      send_op(act, pos, v);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-list cases, bad positions, unused codes, extremes
    send_op(plc_pkg::ACT_SEARCH, 5'd0, 0);
    send_op(plc_pkg::ACT_DEL_HEAD, 5'd0, 0);
    send_op(plc_pkg::ACT_DEL_TAIL, 5'd0, 0);
    send_op(plc_pkg::ACT_SET_HEAD, 5'd0, 3);
    send_op(plc_pkg::ACT_SET_TAIL, 5'd0, 3);
    send_op(plc_pkg::ACT_DEL_AT, 5'd1, 0);
    send_op(plc_pkg::ACT_SET_AT, 5'd0, 3);
    send_op(plc_pkg::ACT_INSERT, 5'd0, 3);
    send_op(plc_pkg::ACT_INSERT, 5'd2, 3);
    send_op(ACT_FIRST_UNUSED, 5'd31, VAL_MAX);
    send_op(ACT_TOP, 5'd31, VAL_MIN);
    send_op(plc_pkg::ACT_INSERT, 5'd1, VAL_MIN);
    send_op(plc_pkg::ACT_ADD_TAIL, 5'd0, VAL_MAX);
    send_op(plc_pkg::ACT_ADD_HEAD, 5'd0, 0);
    send_op(plc_pkg::ACT_INSERT, 5'd4, -1);   // insert just past the tail
    send_op(plc_pkg::ACT_INSERT, 5'd6, 9);
    send_op(plc_pkg::ACT_SEARCH, 5'd0, -1);
    send_op(plc_pkg::ACT_ADD_TAIL, 5'd0, 0);
    send_op(plc_pkg::ACT_SEARCH, 5'd0, 0);    // duplicate: first match wins
    send_op(plc_pkg::ACT_SET_AT, 5'd5, 7);
    send_op(plc_pkg::ACT_SET_AT, 5'd6, 7);
    send_op(plc_pkg::ACT_SET_HEAD, 5'd0, -1);
    send_op(plc_pkg::ACT_DEL_AT, 5'd2, 0);
    send_op(plc_pkg::ACT_DEL_AT, 5'd31, 0);
    send_op(plc_pkg::ACT_DEL_TAIL, 5'd0, 0);

    // Random phases with the idle split swapped, then full throughput
    random_ops(PHASE_ITEMS);
    send_idle_pct = 83;
    recv_idle_pct = 35;
    random_ops(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_ops(PHASE_ITEMS);
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d operations, checked %0d results; list peaked at %0d of %0d entries.",
             sb.ops_noted, sb.results_seen, sb.peak_count, DEPTH);
    $display("Status mix: ok %0d, bad position %0d, empty %0d, not found %0d, full %0d.",
             sb.status_hist[plc_pkg::ST_OK], sb.status_hist[plc_pkg::ST_BADPOS],
             sb.status_hist[plc_pkg::ST_EMPTY], sb.status_hist[plc_pkg::ST_NOTFOUND],
             sb.status_hist[plc_pkg::ST_FULL]);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.awaited.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
